### design/isim_pkg.sv
// Shared types, constants and helpers for the interval set insert/merge block.
`default_nettype none

package isim_pkg;

    // Table capacity and derived widths
    localparam int MAX_INTERVALS = 16;
    localparam int KEY_W         = 64;
    localparam int IDX_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int OUT_CNT_W     = 5;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0] addr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t MAX_CNT = cnt_t'(MAX_INTERVALS);

    // Operation codes
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_READ   = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_INDEX     = 2'd3;

    // One table write
    typedef struct packed {
        logic  en;
        addr_t addr;
        key_t  kbeg;
        key_t  kend;
    } mem_wr_t;

    // Finished result handed to the output register
    typedef struct packed {
        logic       load;
        logic [1:0] status;
        key_t       total;
        cnt_t       count;
        key_t       rbeg;
        key_t       rend;
    } res_t;

    // Count as reported on the port: low five bits
    function automatic logic [OUT_CNT_W-1:0] cnt_out(cnt_t c);
        logic [CNT_W+OUT_CNT_W-1:0] w;
        w = {{OUT_CNT_W{1'b0}}, c};
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/isim_store.sv
// Interval table storage: one write port, one registered read port.
`default_nettype none

module isim_store (
    input  wire logic             aclk,
    input  wire isim_pkg::mem_wr_t wr,
    input  wire isim_pkg::addr_t  rd_addr,
    output isim_pkg::key_t        rd_kbeg,
    output isim_pkg::key_t        rd_kend
);

    isim_pkg::key_t kbeg_mem [isim_pkg::MAX_INTERVALS];
    isim_pkg::key_t kend_mem [isim_pkg::MAX_INTERVALS];

    // Write one entry
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            kbeg_mem[wr.addr] <= wr.kbeg;
            kend_mem[wr.addr] <= wr.kend;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rd_kbeg <= kbeg_mem[rd_addr];
        rd_kend <= kend_mem[rd_addr];
    end

endmodule

`default_nettype wire

### design/isim_ctrl.sv
// Sequencer: scans the table one entry a cycle, merges, shifts entries and keeps count/total.
`default_nettype none

module isim_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_accept,
    input  wire logic [1:0]          in_func,
    input  wire isim_pkg::key_t      in_begin,
    input  wire isim_pkg::key_t      in_end,
    input  wire logic [3:0]          in_index,
    input  wire logic                out_free,
    input  wire isim_pkg::key_t      rd_kbeg,
    input  wire isim_pkg::key_t      rd_kend,
    output isim_pkg::addr_t          rd_addr,
    output isim_pkg::mem_wr_t        wr,
    output logic                     idle,
    output isim_pkg::res_t           res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_DOWN = 3'd3;
    localparam logic [2:0] S_WRLO = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam isim_pkg::cnt_t ONE = isim_pkg::cnt_t'(1);

    logic [2:0]           state_reg, state_next;
    logic                 run_reg, run_next;
    logic                 dvalid_reg, dvalid_next;
    isim_pkg::cnt_t       ptr_reg, ptr_next;
    isim_pkg::cnt_t       dptr_reg, dptr_next;
    isim_pkg::cnt_t       lo_reg, lo_next;
    isim_pkg::cnt_t       rem_reg, rem_next;
    isim_pkg::cnt_t       cnt_reg, cnt_next;
    isim_pkg::key_t       total_reg, total_next;
    isim_pkg::key_t       b_reg, b_next;
    isim_pkg::key_t       e_reg, e_next;
    isim_pkg::key_t       mb_reg, mb_next;
    isim_pkg::key_t       me_reg, me_next;
    isim_pkg::key_t       rb_reg, rb_next;
    isim_pkg::key_t       re_reg, re_next;
    logic [1:0]           status_reg, status_next;

    logic [isim_pkg::CNT_W+3:0] idx_wide;
    logic                       idx_ok;
    isim_pkg::cnt_t             cnt_last;
    isim_pkg::cnt_t             lo_new, rem_new, hi_new;
    isim_pkg::cnt_t             up_dst, down_dst;
    logic                       is_before, is_absorb, last_data, scan_done;

    assign idx_wide = {{isim_pkg::CNT_W{1'b0}}, in_index};
    assign idx_ok   = idx_wide < {4'b0, cnt_reg};
    assign cnt_last = cnt_reg - ONE;
    assign rd_addr  = ptr_reg[isim_pkg::IDX_W-1:0];
    assign idle     = (state_reg == S_IDLE);

    // Classify the entry that just came out of the table
    assign is_before = rd_kend < b_reg;
    assign is_absorb = !is_before && (rd_kbeg <= e_reg);
    assign last_data = (dptr_reg == cnt_last);
    assign lo_new    = is_before ? lo_reg + ONE : lo_reg;
    assign rem_new   = is_absorb ? rem_reg + ONE : rem_reg;
    assign hi_new    = lo_new + rem_new;
    assign scan_done = dvalid_reg && (last_data || (!is_before && !is_absorb));
    assign up_dst    = dptr_reg + ONE;
    assign down_dst  = dptr_reg - rem_reg + ONE;

    always_comb begin
        state_next  = state_reg;
        run_next    = run_reg;
        ptr_next    = ptr_reg;
        lo_next     = lo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        b_next      = b_reg;
        e_next      = e_reg;
        mb_next     = mb_reg;
        me_next     = me_reg;
        rb_next     = rb_reg;
        re_next     = re_reg;
        status_next = status_reg;
        wr          = '0;
        res         = '0;

        // Advance the read pointer while a pass is running
        if (run_reg) begin
            unique case (state_reg)
                S_UP: begin
                    if (ptr_reg == lo_reg) run_next = 1'b0;
                    else                   ptr_next = ptr_reg - ONE;
                end
                S_RD: run_next = 1'b0;
                default: begin
                    if (ptr_reg == cnt_last) run_next = 1'b0;
                    else                     ptr_next = ptr_reg + ONE;
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    b_next      = in_begin;
                    e_next      = in_end;
                    mb_next     = in_begin;
                    me_next     = in_end;
                    lo_next     = '0;
                    rem_next    = '0;
                    rb_next     = '0;
                    re_next     = '0;
                    status_next = isim_pkg::ST_OK;
                    state_next  = S_FIN;
                    unique case (in_func)
                        isim_pkg::FN_INSERT: begin
                            if (in_begin > in_end) begin
                                status_next = isim_pkg::ST_MALFORMED;
                            end else if (in_begin == in_end) begin
                                state_next = S_FIN;
                            end else if (cnt_reg == '0) begin
                                state_next = S_WRLO;
                            end else begin
                                state_next = S_SCAN;
                                ptr_next   = '0;
                                run_next   = 1'b1;
                            end
                        end
                        isim_pkg::FN_READ: begin
                            if (idx_ok) begin
                                state_next = S_RD;
                                ptr_next   = idx_wide[isim_pkg::CNT_W-1:0];
                                run_next   = 1'b1;
                            end else begin
                                status_next = isim_pkg::ST_INDEX;
                            end
                        end
                        isim_pkg::FN_CLEAR: begin
                            cnt_next   = '0;
                            total_next = '0;
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end

            S_SCAN: begin
                if (dvalid_reg) begin
                    lo_next  = lo_new;
                    rem_next = rem_new;
                    // Fold an overlapping or touching entry into the new one
                    if (is_absorb) begin
                        mb_next    = (rd_kbeg < mb_reg) ? rd_kbeg : mb_reg;
                        me_next    = (rd_kend > me_reg) ? rd_kend : me_reg;
                        total_next = total_reg - rd_kend + rd_kbeg;
                    end
                end
                if (scan_done) begin
                    run_next = 1'b0;
                    if (rem_new == '0 && cnt_reg == isim_pkg::MAX_CNT) begin
                        status_next = isim_pkg::ST_FULL;
                        state_next  = S_FIN;
                    end else if (rem_new == '0) begin
                        if (lo_new < cnt_reg) begin
                            state_next = S_UP;
                            ptr_next   = cnt_last;
                            run_next   = 1'b1;
                        end else begin
                            state_next = S_WRLO;
                        end
                    end else if (rem_new == ONE || hi_new >= cnt_reg) begin
                        state_next = S_WRLO;
                    end else begin
                        state_next = S_DOWN;
                        ptr_next   = hi_new;
                        run_next   = 1'b1;
                    end
                end
            end

            // Open a gap at lo: move entries up by one, top first
            S_UP: begin
                if (dvalid_reg) begin
                    wr.en   = 1'b1;
                    wr.addr = up_dst[isim_pkg::IDX_W-1:0];
                    wr.kbeg = rd_kbeg;
                    wr.kend = rd_kend;
                    if (dptr_reg == lo_reg) begin
                        state_next = S_WRLO;
                        run_next   = 1'b0;
                    end
                end
            end

            // Close the hole left by absorbed entries, bottom first
            S_DOWN: begin
                if (dvalid_reg) begin
                    wr.en   = 1'b1;
                    wr.addr = down_dst[isim_pkg::IDX_W-1:0];
                    wr.kbeg = rd_kbeg;
                    wr.kend = rd_kend;
                    if (last_data) begin
                        state_next = S_WRLO;
                        run_next   = 1'b0;
                    end
                end
            end

            S_WRLO: begin
                wr.en      = 1'b1;
                wr.addr    = lo_reg[isim_pkg::IDX_W-1:0];
                wr.kbeg    = mb_reg;
                wr.kend    = me_reg;
                cnt_next   = cnt_reg - rem_reg + ONE;
                total_next = total_reg + me_reg - mb_reg;
                state_next = S_FIN;
            end

            S_RD: begin
                if (dvalid_reg) begin
                    rb_next    = rd_kbeg;
                    re_next    = rd_kend;
                    state_next = S_FIN;
                end
            end

            // Hold the result until the output register is free
            S_FIN: begin
                res.load   = out_free;
                res.status = status_reg;
                res.total  = total_reg;
                res.count  = cnt_reg;
                res.rbeg   = rb_reg;
                res.rend   = re_reg;
                if (out_free) state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Data arriving next cycle belongs to this pass only
    assign dvalid_next = run_reg && (state_next == state_reg);
    assign dptr_next   = ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            run_reg    <= 1'b0;
            dvalid_reg <= 1'b0;
            cnt_reg    <= '0;
            total_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            run_reg    <= run_next;
            dvalid_reg <= dvalid_next;
            cnt_reg    <= cnt_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        dptr_reg   <= dptr_next;
        lo_reg     <= lo_next;
        rem_reg    <= rem_next;
        b_reg      <= b_next;
        e_reg      <= e_next;
        mb_reg     <= mb_next;
        me_reg     <= me_next;
        rb_reg     <= rb_next;
        re_reg     <= re_next;
        status_reg <= status_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= isim_pkg::MAX_CNT)
        else $error("entry count above capacity");

    a_wr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (state_reg == S_UP || state_reg == S_DOWN || state_reg == S_WRLO))
        else $error("table written outside a shift or merge write");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res.load |=> state_reg == S_IDLE)
        else $error("sequencer not idle after handing off a result");

    a_merge_span: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WRLO |->
            ({1'b0, lo_reg} + {1'b0, rem_reg}) <= {1'b0, cnt_reg})
        else $error("merged span runs past the entry count");

    a_data_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        dvalid_reg |-> $past(run_reg))
        else $error("read data flagged without a read issued");

endmodule

`default_nettype wire

### design/interval_set_insert_merge.sv
// Top level: interval set with merging insert, entry read and clear.
`default_nettype none

// Keeps up to isim_pkg::MAX_INTERVALS sorted, disjoint half-open intervals and
// the total number of keys they cover. Each item yields exactly one result.
// Items are taken one at a time; s_ready is high only while the sequencer is
// idle, and a finished result waits in the output register while the next item
// is accepted. An insert scans entries up to the first entry past the new
// interval, moves entries where a gap must be opened or closed and writes the
// merged interval; into an empty table it writes at once, and a full table
// with nothing to absorb ends the scan with a full status. A read fetches one
// entry; clear, empty, malformed and unused codes go straight to the result.
// A result that finds the output register still occupied holds the sequencer
// until m_ready frees it. The pace is set by the table's single registered
// read port, which delivers one entry per cycle to the compare and accumulate
// logic.
module interval_set_insert_merge (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [63:0] s_range_begin,
    input  wire logic [63:0] s_range_end,
    input  wire logic [3:0]  s_entry_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [63:0]      m_covered_total,
    output logic [4:0]       m_interval_count,
    output logic [63:0]      m_read_begin,
    output logic [63:0]      m_read_end
);

    isim_pkg::mem_wr_t wr;
    isim_pkg::addr_t   rd_addr;
    isim_pkg::key_t    rd_kbeg, rd_kend;
    isim_pkg::res_t    res;
    logic              idle;
    logic              in_accept;
    logic              out_free;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        status_reg;
    logic [63:0]       total_reg;
    logic [4:0]        count_reg;
    logic [63:0]       rbeg_reg;
    logic [63:0]       rend_reg;

    assign s_ready   = idle;
    assign in_accept = s_valid && idle;
    assign out_free  = !m_valid_reg || m_ready;

    isim_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_kbeg (rd_kbeg),
        .rd_kend (rd_kend)
    );

    isim_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_func   (s_func),
        .in_begin  (s_range_begin),
        .in_end    (s_range_end),
        .in_index  (s_entry_index),
        .out_free  (out_free),
        .rd_kbeg   (rd_kbeg),
        .rd_kend   (rd_kend),
        .rd_addr   (rd_addr),
        .wr        (wr),
        .idle      (idle),
        .res       (res)
    );

    // Output register: load a result, drop it once taken
    assign m_valid_next = res.load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.load) begin
            status_reg <= res.status;
            total_reg  <= res.total;
            count_reg  <= isim_pkg::cnt_out(res.count);
            rbeg_reg   <= res.rbeg;
            rend_reg   <= res.rend;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_covered_total  = total_reg;
    assign m_interval_count = count_reg;
    assign m_read_begin     = rbeg_reg;
    assign m_read_end       = rend_reg;

endmodule

`default_nettype wire
